// ===== rtl/tod_pkg.sv =====
// Shared types, constants and helper functions for the time-of-day text parser.
package tod_pkg;

   // Field widths
   localparam int CHAR_W    = 8;
   localparam int HOUR_W    = 5;
   localparam int MIN_W     = 6;
   localparam int SEC_W     = 6;
   localparam int FRAC_W    = 20;
   localparam int SECS_W    = 17;
   localparam int TIME_US_W = 37;
   localparam int POS_W     = 8;

   // Default saturation point of the byte position counter
   localparam int POS_LIMIT_DEF = 255;

   // Arithmetic constants
   localparam int SEC_PER_HOUR = 3600;
   localparam int SEC_PER_MIN  = 60;
   localparam int USEC_PER_SEC = 1000000;
   localparam int HOUR_MAX     = 23;
   localparam int MIN_MAX      = 59;
   localparam int FRAC_DIGITS  = 6;

   // Largest time of day in microseconds
   localparam logic [TIME_US_W-1:0] TIME_US_MAX = 37'd86399999999;

   // One input word: a byte of the string and its framing flags
   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
      logic              empty_string;
   } req_word_type;

   // One result word
   typedef struct packed {
      logic                 parse_ok;
      logic [TIME_US_W-1:0] time_us;
      logic [POS_W-1:0]     stop_pos;
   } rsp_word_type;

   // Parsed string handed from the byte parser to the time arithmetic
   typedef struct packed {
      logic              ok;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
      logic [FRAC_W-1:0] frac;
      logic [POS_W-1:0]  pos;
   } fin_type;

   // Weight of the n-th fraction digit in microseconds
   function automatic logic [FRAC_W-1:0] frac_weight(input logic [2:0] n);
      logic [FRAC_W-1:0] w;
      unique case (n)
         3'd0:    w = 20'd100000;
         3'd1:    w = 20'd10000;
         3'd2:    w = 20'd1000;
         3'd3:    w = 20'd100;
         3'd4:    w = 20'd10;
         3'd5:    w = 20'd1;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/tod_parser.sv =====
// Byte-at-a-time parse state machine for HH[:MM[:SS[.ffffff]]] strings.
module tod_parser import tod_pkg::*; #(
   parameter int POS_LIMIT = POS_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         strict_mode,
   input  logic         take,
   input  req_word_type word,
   output logic         emit,
   output fin_type      fin
);

   localparam int CNT_W = $clog2(POS_LIMIT + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(POS_LIMIT);

   // Parse phases
   localparam logic [3:0] P_LEAD  = 4'd0;
   localparam logic [3:0] P_HOUR  = 4'd1;
   localparam logic [3:0] P_HSEP  = 4'd2;
   localparam logic [3:0] P_MIN   = 4'd3;
   localparam logic [3:0] P_MSEP  = 4'd4;
   localparam logic [3:0] P_SEC   = 4'd5;
   localparam logic [3:0] P_SAFT  = 4'd6;
   localparam logic [3:0] P_FRAC  = 4'd7;
   localparam logic [3:0] P_TRAIL = 4'd8;

   // Character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   logic [3:0]        phase_ff, phase_in;
   logic [HOUR_W-1:0] hour_ff, hour_in;
   logic [MIN_W-1:0]  min_ff, min_in;
   logic [SEC_W-1:0]  sec_ff, sec_in;
   logic [1:0]        fdig_ff, fdig_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [2:0]        fcnt_ff, fcnt_in;
   logic              failed_ff, failed_in;
   logic              stopped_ff, stopped_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  stop_ff, stop_in;

   logic [7:0]       c;
   logic [3:0]       dval;
   logic             is_dig, is_sp;
   logic [CNT_W-1:0] idx_inc;
   logic [3:0]       field_cur;
   logic [6:0]       field_val;
   logic [6:0]       field_lim;
   logic             field_wr;
   logic [5:0]       field_new;
   logic             do_sep, do_after, do_trail;
   logic [3:0]       sep_next;
   logic             done;
   logic             fin_ok;
   logic [CNT_W-1:0] fin_pos;

   // Classify the byte
   assign c       = word.text_char;
   assign dval    = c[3:0];
   assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_sp   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign idx_inc = (count_ff >= CNT_LIMIT) ? CNT_LIMIT : count_ff + 1'b1;

   // Second digit of a two-digit field
   always_comb begin
      if (phase_ff == P_HOUR) begin
         field_cur = hour_ff[3:0];
         field_lim = 7'(HOUR_MAX);
      end else if (phase_ff == P_MIN) begin
         field_cur = min_ff[3:0];
         field_lim = 7'(MIN_MAX);
      end else begin
         field_cur = sec_ff[3:0];
         field_lim = 7'(MIN_MAX);
      end
      field_val = 7'(field_cur) * 7'd10 + 7'(dval);
   end

   // Advance the parse by one byte
   always_comb begin
      phase_in   = phase_ff;
      hour_in    = hour_ff;
      min_in     = min_ff;
      sec_in     = sec_ff;
      fdig_in    = fdig_ff;
      frac_in    = frac_ff;
      fcnt_in    = fcnt_ff;
      failed_in  = failed_ff;
      stopped_in = stopped_ff;
      stop_in    = stop_ff;
      count_in   = idx_inc;
      field_wr   = 1'b0;
      field_new  = '0;
      do_sep     = 1'b0;
      do_after   = 1'b0;
      do_trail   = 1'b0;
      sep_next   = P_MIN;

      if (!failed_ff && !stopped_ff) begin
         unique case (phase_ff)
            P_LEAD: begin
               if (is_dig) begin
                  hour_in  = HOUR_W'(dval);
                  fdig_in  = 2'd1;
                  phase_in = P_HOUR;
               end else if (!is_sp) begin
                  failed_in = 1'b1;
                  stop_in   = count_ff;
               end
            end
            P_HOUR, P_MIN, P_SEC: begin
               if (is_dig) begin
                  if (fdig_ff == 2'd0) begin
                     field_wr  = 1'b1;
                     field_new = 6'(dval);
                     fdig_in   = 2'd1;
                  end else if (field_val > field_lim) begin
                     failed_in = 1'b1;
                     stop_in   = idx_inc;
                  end else begin
                     field_wr  = 1'b1;
                     field_new = field_val[5:0];
                     fdig_in   = 2'd2;
                     phase_in  = (phase_ff == P_HOUR) ? P_HSEP :
                                 (phase_ff == P_MIN)  ? P_MSEP : P_SAFT;
                  end
               end else if (fdig_ff == 2'd0) begin
                  failed_in = 1'b1;
                  stop_in   = count_ff;
               end else if (phase_ff == P_SEC) begin
                  do_after = 1'b1;
               end else begin
                  do_sep   = 1'b1;
                  sep_next = (phase_ff == P_HOUR) ? P_MIN : P_SEC;
               end
            end
            P_HSEP: begin
               do_sep   = 1'b1;
               sep_next = P_MIN;
            end
            P_MSEP: begin
               do_sep   = 1'b1;
               sep_next = P_SEC;
            end
            P_SAFT: begin
               do_after = 1'b1;
            end
            P_FRAC: begin
               if (is_dig) begin
                  if (fcnt_ff < 3'(FRAC_DIGITS)) begin
                     frac_in = frac_ff + 20'(dval) * frac_weight(fcnt_ff);
                     fcnt_in = fcnt_ff + 3'd1;
                  end
               end else begin
                  do_trail = 1'b1;
               end
            end
            default: begin
               // trailing space phase
               if (!is_sp) begin
                  failed_in = 1'b1;
                  stop_in   = count_ff;
               end
            end
         endcase

         // Write the field being read
         if (field_wr) begin
            if (phase_ff == P_HOUR) begin
               hour_in = HOUR_W'(field_new);
            end else if (phase_ff == P_MIN) begin
               min_in = field_new;
            end else begin
               sec_in = field_new;
            end
         end

         // Separator between fields
         if (do_sep) begin
            if (c == CH_COLON) begin
               phase_in = sep_next;
               fdig_in  = 2'd0;
            end else begin
               failed_in = 1'b1;
               stop_in   = idx_inc;
            end
         end

         // Byte after the seconds: fraction point or trailing byte
         if (do_after) begin
            if (c == CH_DOT) begin
               phase_in = P_FRAC;
            end else begin
               do_trail = 1'b1;
            end
         end

         // Trailing byte: strict mode allows only spaces
         if (do_trail) begin
            if (strict_mode) begin
               if (is_sp) begin
                  phase_in = P_TRAIL;
               end else begin
                  failed_in = 1'b1;
                  stop_in   = count_ff;
               end
            end else begin
               stopped_in = 1'b1;
               stop_in    = count_ff;
            end
         end
      end
   end

   // Build the result for the last byte or an empty string
   always_comb begin
      if (failed_in) begin
         fin_ok  = 1'b0;
         fin_pos = stop_in;
      end else if (stopped_in) begin
         fin_ok  = 1'b1;
         fin_pos = stop_in;
      end else begin
         fin_pos = count_in;
         fin_ok  = !((phase_in == P_LEAD) ||
                     (((phase_in == P_MIN) || (phase_in == P_SEC)) && (fdig_in == 2'd0)));
      end

      if (word.empty_string) begin
         fin = '0;
      end else begin
         fin.ok     = fin_ok;
         fin.hour   = fin_ok ? hour_in : '0;
         fin.minute = fin_ok ? min_in  : '0;
         fin.second = fin_ok ? sec_in  : '0;
         fin.frac   = fin_ok ? frac_in : '0;
         fin.pos    = POS_W'(fin_pos);
      end
   end

   assign done = take && (word.last_char || word.empty_string);
   assign emit = done;

   // Hold, advance, or clear the parse state
   always_ff @(posedge clock) begin
      if (reset || done) begin
         phase_ff   <= P_LEAD;
         hour_ff    <= '0;
         min_ff     <= '0;
         sec_ff     <= '0;
         fdig_ff    <= '0;
         frac_ff    <= '0;
         fcnt_ff    <= '0;
         failed_ff  <= 1'b0;
         stopped_ff <= 1'b0;
         count_ff   <= '0;
         stop_ff    <= '0;
      end else if (take) begin
         phase_ff   <= phase_in;
         hour_ff    <= hour_in;
         min_ff     <= min_in;
         sec_ff     <= sec_in;
         fdig_ff    <= fdig_in;
         frac_ff    <= frac_in;
         fcnt_ff    <= fcnt_in;
         failed_ff  <= failed_in;
         stopped_ff <= stopped_in;
         count_ff   <= count_in;
         stop_ff    <= stop_in;
      end
   end

endmodule

// ===== rtl/tod_time_pipe.sv =====
// Three-stage pipeline that turns a parsed time into microseconds of the day.
module tod_time_pipe import tod_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  fin_type      in_fin,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_word_type out_word
);

   logic         s1_valid_ff;
   fin_type      s1_fin_ff;
   logic         s2_valid_ff;
   logic         s2_ok_ff;
   logic [SECS_W-1:0] s2_secs_ff, s2_secs_in;
   logic [FRAC_W-1:0] s2_frac_ff;
   logic [POS_W-1:0]  s2_pos_ff;
   logic         s3_valid_ff;
   rsp_word_type s3_word_ff, s3_word_in;
   logic         s1_ready, s2_ready, s3_ready;

   // Each stage moves when the one after it has room
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Seconds of the day from constant multiplies
   assign s2_secs_in = SECS_W'(s1_fin_ff.hour) * SECS_W'(SEC_PER_HOUR)
                     + SECS_W'(s1_fin_ff.minute) * SECS_W'(SEC_PER_MIN)
                     + SECS_W'(s1_fin_ff.second);

   // Scale to microseconds and add the fraction
   always_comb begin
      s3_word_in.parse_ok = s2_ok_ff;
      s3_word_in.time_us  = TIME_US_W'(s2_secs_ff) * TIME_US_W'(USEC_PER_SEC)
                          + TIME_US_W'(s2_frac_ff);
      s3_word_in.stop_pos = s2_pos_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_fin_ff <= in_fin;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ok_ff   <= s1_fin_ff.ok;
         s2_secs_ff <= s2_secs_in;
         s2_frac_ff <= s1_fin_ff.frac;
         s2_pos_ff  <= s1_fin_ff.pos;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_word_ff <= s3_word_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_word  = s3_word_ff;

endmodule

// ===== rtl/time_of_day_text_parser_core.sv =====
// Time-of-day text parser: one string byte per word in, one parse result per string out.
// Takes one byte per clock cycle with no gaps while req_ready is high. The input stalls
// only when all three pipe registers hold results and the receiver is not ready. The
// result of a string passes through the three pipe registers in order after its last
// byte is accepted, and is then presented on rsp_word. The three registers are one for
// the parsed fields, one after the hour/minute constant multiplies, and one after the
// 17 x 20 bit microsecond multiply.
// Leading spaces are skipped, then HH[:MM[:SS[.fraction]]] is read; only six fraction
// digits count. In strict mode (csr_wdata bit, reset 1) only spaces may follow the
// seconds or fraction. An empty_string word yields a failed result at once. The
// byte position saturates at POS_LIMIT and stop_pos carries its low eight bits.
// No clearing pass is needed after reset.
module time_of_day_text_parser_core import tod_pkg::*; #(
   parameter int POS_LIMIT = POS_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_wdata
);

   logic    strict_ff;
   logic    take;
   logic    emit;
   fin_type fin;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         strict_ff <= csr_wdata;
      end
   end

   assign take = req_valid && req_ready;

   // Byte parser
   tod_parser #(
      .POS_LIMIT (POS_LIMIT)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .strict_mode (strict_ff),
      .take        (take),
      .word        (req_word),
      .emit        (emit),
      .fin         (fin)
   );

   // Time arithmetic and output register
   tod_time_pipe u_time_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit),
      .in_ready  (req_ready),
      .in_fin    (fin),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

   // A failed parse reports zero time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.parse_ok |-> rsp_word.time_us == '0)
      else $error("failed parse with nonzero time");

   // Time never passes the end of the day
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.time_us <= TIME_US_MAX)
      else $error("time of day out of range");

   // Input stalls only when a result is waiting at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with output free");

endmodule
